// ===== design/rwdi_pkg.sv =====
`timescale 1ns / 1ps
// Types, register codes and constant tables for the radial wave delay intensity block.
// No dependencies.
package rwdi_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_STEPMUL, S_STEPDIV, S_ADDR, S_READ, S_SMP,
    S_NORM, S_LOG, S_PMUL, S_EXP, S_SCALE, S_QSTART, S_QDIV, S_FIN
  } rwdi_state_t;

  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [2:0] REG_WAVE_SPEED  = 3'd3;
  localparam logic [2:0] REG_DECAY       = 3'd4;
  localparam logic [2:0] REG_FRAME_RATE  = 3'd5;
  localparam logic [2:0] REG_COLOR       = 3'd6;

  localparam logic [16:0] POW_ONE = 17'd4096;
  localparam logic [16:0] POW_MAX = 17'd40960;

  typedef logic [30:0] root_tab_t [16];

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] t;
    vv = v;
    r  = '0;
    b  = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        t = r + b;
        if (vv >= t) begin
          vv = vv - t;
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30 for k = 1..16, each a floor square root of the previous
  function automatic root_tab_t build_roots();
    root_tab_t tab;
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int k = 0; k < 16; k++) begin
      c      = isqrt_c(c << 30);
      tab[k] = c[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t EXP_ROOT = build_roots();

endpackage

// ===== design/radial_wave_delay_intensity_top.sv =====
`timescale 1ns / 1ps
// Radial wave delay intensity: sample history memory, sequencer and shared datapath.
// Depends on rwdi_pkg.
//
// A push transfer writes one sample into the history. A query transfer runs through
// one shared 33x33 multiplier, a bit-serial square root and a shared bit-serial
// divider under a small sequencer: squares, root, a product and a divide for the
// delay step count, the history read, normalize, log2 squarings, a product, exp2
// steps, a scale, the final divide and loading the result. At zero distance the
// normalize to scale steps are skipped, and when the power saturates at either bound
// the exp2 steps and scale are skipped. in_stall is high from the query transfer
// until the result is loaded, including any wait for the output register.
// The result sits in an output register, so the next transfer is taken while it waits.
// The history has no clearing pass: a fill count marks entries never written, and
// those read as zero.
module radial_wave_delay_intensity_top #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [15:0]        in_sample,
  input  logic signed [15:0] in_light_x,
  input  logic signed [15:0] in_light_y,
  input  logic signed [15:0] in_light_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_intensity,
  output logic [31:0]        out_color_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import rwdi_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);

  // configuration
  logic signed [15:0] org_x_r, org_y_r, org_z_r, decay_r;
  logic [15:0] speed_r;
  logic [7:0]  frame_r;
  logic [31:0] color_r;

  // history
  logic [15:0]   hist_mem [HISTORY_DEPTH];
  logic [15:0]   rd_data_r;
  logic [AW-1:0] newest_r;
  logic [FW-1:0] fill_r;

  // sequencer and datapath
  rwdi_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic signed [15:0] lx_r, ly_r, lz_r;
  logic [33:0] acc_r, acc_nxt;
  logic [33:0] sq_src_r, sq_src_nxt;
  logic [16:0] root_r, root_nxt;
  logic [18:0] srem_r, srem_nxt;
  logic [27:0] dnum_r, dnum_nxt;
  logic [16:0] dden_r, dden_nxt;
  logic [16:0] drem_r, drem_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic        ok_r, ok_nxt;
  logic [15:0] smp_r, smp_nxt;
  logic [30:0] m_r, m_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [17:0] pq_r, pq_nxt;
  logic [30:0] r_r, r_nxt;
  logic [16:0] pow_r, pow_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_int_r, out_int_nxt;
  logic [31:0] out_col_r, out_col_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_intensity = out_int_r;
  assign out_color_out = out_col_r;
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= 16'sd256;
      org_y_r <= 16'sd256;
      org_z_r <= 16'sd256;
      speed_r <= 16'd256;
      decay_r <= 16'sd4096;
      frame_r <= 8'd60;
      color_r <= 32'h8080_80FF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:   org_x_r <= cfg_wdata[15:0];
        REG_ORIGIN_Y:   org_y_r <= cfg_wdata[15:0];
        REG_ORIGIN_Z:   org_z_r <= cfg_wdata[15:0];
        REG_WAVE_SPEED: speed_r <= cfg_wdata[15:0];
        REG_DECAY:      decay_r <= cfg_wdata[15:0];
        REG_FRAME_RATE: frame_r <= cfg_wdata[7:0];
        REG_COLOR:      color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // history write on push, registered read every cycle
  logic [AW-1:0] push_slot;
  assign push_slot = (newest_r == AW'(HISTORY_DEPTH - 1)) ? '0 : newest_r + 1'b1;

  always_ff @(posedge clk) begin
    if (in_xfer && !in_command) begin
      hist_mem[push_slot] <= in_sample;
    end
    rd_data_r <= hist_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      fill_r   <= '0;
    end else if (in_xfer && !in_command) begin
      newest_r <= push_slot;
      if (fill_r != FW'(HISTORY_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_command) begin
      lx_r <= in_light_x;
      ly_r <= in_light_y;
      lz_r <= in_light_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    sq_src_r  <= sq_src_nxt;
    root_r    <= root_nxt;
    srem_r    <= srem_nxt;
    dnum_r    <= dnum_nxt;
    dden_r    <= dden_nxt;
    drem_r    <= drem_nxt;
    addr_r    <= addr_nxt;
    ok_r      <= ok_nxt;
    smp_r     <= smp_nxt;
    m_r       <= m_nxt;
    n_r       <= n_nxt;
    frac_r    <= frac_nxt;
    pq_r      <= pq_nxt;
    r_r       <= r_nxt;
    pow_r     <= pow_nxt;
    out_int_r <= out_int_nxt;
    out_col_r <= out_col_nxt;
  end

  // shared multiplier operand selection
  logic signed [15:0] sel_l, sel_o;
  logic signed [16:0] diff;
  logic signed [5:0]  lg_int;
  logic signed [21:0] lg;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin sel_l = lx_r; sel_o = org_x_r; end
      2'd1:    begin sel_l = ly_r; sel_o = org_y_r; end
      default: begin sel_l = lz_r; sel_o = org_z_r; end
    endcase
    diff   = 17'(sel_l) - 17'(sel_o);
    lg_int = $signed({1'b0, n_r}) - 6'sd8;
    lg     = {lg_int, frac_r};
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_SQ:      begin mul_a = 33'(diff); mul_b = 33'(diff); end
      S_STEPMUL: begin mul_a = $signed({16'd0, root_r}); mul_b = $signed({25'd0, frame_r}); end
      S_LOG:     begin mul_a = $signed({2'd0, m_r}); mul_b = $signed({2'd0, m_r}); end
      S_PMUL:    begin mul_a = 33'(lg); mul_b = 33'(decay_r); end
      S_EXP:     begin
        mul_a = $signed({2'd0, r_r});
        mul_b = $signed({2'd0, EXP_ROOT[cnt_r[3:0]]});
      end
      default: ;
    endcase
  end

  // datapath scratch
  logic [20:0] rem_t;
  logic [20:0] trial;
  logic [17:0] drem_t;
  logic [15:0] speed_eff;
  logic [27:0] steps;
  logic [AW+1:0] pos;
  logic [18:0] x3;
  logic [31:0] sq_t;
  logic signed [37:0] prod;
  logic [25:0] pq;
  logic [62:0] rnd;
  logic [33:0] rs;
  logic [34:0] q_t;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    sq_src_nxt    = sq_src_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    dnum_nxt      = dnum_r;
    dden_nxt      = dden_r;
    drem_nxt      = drem_r;
    addr_nxt      = addr_r;
    ok_nxt        = ok_r;
    smp_nxt       = smp_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    frac_nxt      = frac_r;
    pq_nxt        = pq_r;
    r_nxt         = r_r;
    pow_nxt       = pow_r;
    out_int_nxt   = out_int_r;
    out_col_nxt   = out_col_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;

    rem_t     = {srem_r[18:0], sq_src_r[33:32]} & 21'h1FFFFF;
    trial     = {2'b00, root_r, 2'b01};
    drem_t    = {drem_r, dnum_r[27]};
    speed_eff = (speed_r == 16'd0) ? 16'd1 : speed_r;
    steps     = dnum_r;
    pos       = (AW+2)'(newest_r) + (AW+2)'(HISTORY_DEPTH) - (AW+2)'(steps);
    x3        = {2'b00, root_r} + {1'b0, root_r, 1'b0};
    sq_t      = mul_p[61:30];
    prod      = mul_p[37:0];
    pq        = prod[37:12];
    rnd       = mul_p[62:0] + 63'h2000_0000;
    rs        = 34'(r_r) << pq_r[17:16];
    q_t       = (35'(rs) + 35'h2_0000) >> 18;

    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_command) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        acc_nxt = acc_r + mul_p[33:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd2) begin
          sq_src_nxt = acc_r + mul_p[33:0];
          root_nxt   = '0;
          srem_nxt   = '0;
          cnt_nxt    = '0;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        // one root bit per cycle, two radicand bits in
        rem_t = {srem_r, sq_src_r[33:32]};
        if (rem_t >= trial) begin
          srem_nxt = 19'(rem_t - trial);
          root_nxt = {root_r[15:0], 1'b1};
        end else begin
          srem_nxt = rem_t[18:0];
          root_nxt = {root_r[15:0], 1'b0};
        end
        sq_src_nxt = {sq_src_r[31:0], 2'b00};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == 5'd16) begin
          cnt_nxt   = '0;
          state_nxt = S_STEPMUL;
        end
      end
      S_STEPMUL: begin
        dnum_nxt  = 28'({mul_p[24:0], 1'b0}) + 28'(speed_eff);
        dden_nxt  = {speed_eff, 1'b0};
        drem_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_STEPDIV;
      end
      S_STEPDIV, S_QDIV: begin
        // restoring divide, quotient shifts into the dividend register
        if (drem_t >= {1'b0, dden_r}) begin
          drem_nxt = 17'(drem_t - {1'b0, dden_r});
          dnum_nxt = {dnum_r[26:0], 1'b1};
        end else begin
          drem_nxt = drem_t[16:0];
          dnum_nxt = {dnum_r[26:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd27) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == S_STEPDIV) ? S_ADDR : S_FIN;
        end
      end
      S_ADDR: begin
        ok_nxt    = (steps < 28'(fill_r));
        addr_nxt  = (pos >= (AW+2)'(HISTORY_DEPTH)) ?
                    AW'(pos - (AW+2)'(HISTORY_DEPTH)) : AW'(pos);
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_SMP;
      end
      S_SMP: begin
        smp_nxt = ok_r ? rd_data_r : 16'd0;
        if (x3 == '0) begin
          pow_nxt   = decay_r[15] ? POW_MAX : POW_ONE;
          state_nxt = S_QSTART;
        end else begin
          m_nxt     = {12'd0, x3};
          n_nxt     = 5'd30;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (m_r[30]) begin
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_LOG;
        end else begin
          m_nxt = {m_r[29:0], 1'b0};
          n_nxt = n_r - 1'b1;
        end
      end
      S_LOG: begin
        if (sq_t[31]) begin
          m_nxt    = sq_t[31:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          m_nxt    = sq_t[30:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd15) begin
          cnt_nxt   = '0;
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        if (prod[37] || prod == '0 || pq == '0) begin
          pow_nxt   = POW_ONE;
          state_nxt = S_QSTART;
        end else if (|pq[25:18]) begin
          pow_nxt   = POW_MAX;
          state_nxt = S_QSTART;
        end else begin
          pq_nxt    = pq[17:0];
          r_nxt     = 31'h4000_0000;
          cnt_nxt   = '0;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (pq_r[4'd15 - cnt_r[3:0]]) begin
          r_nxt = rnd[60:30];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd15) begin
          cnt_nxt   = '0;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (q_t < 35'(POW_ONE)) begin
          pow_nxt = POW_ONE;
        end else if (q_t > 35'(POW_MAX)) begin
          pow_nxt = POW_MAX;
        end else begin
          pow_nxt = q_t[16:0];
        end
        state_nxt = S_QSTART;
      end
      S_QSTART: begin
        dnum_nxt  = {smp_r, 12'd0};
        dden_nxt  = pow_r;
        drem_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_QDIV;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_int_nxt   = dnum_r[15:0];
          out_col_nxt   = (dnum_r[15:0] != 16'd0) ? color_r : 32'd0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rwdi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the radial wave delay intensity top level, with its bind.
// Sees the top level's ports only.
module rwdi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_intensity,
  input logic [31:0] out_color_out
);

  // a query keeps the input side closed while it computes
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command |=> in_stall)
    else $error("input taken right after a query transfer");

  // a push never produces a result
  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_command && !out_valid |=> !out_valid)
    else $error("result appeared after a push");

  // black whenever the intensity is zero
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_intensity == 16'd0 |-> out_color_out == 32'd0)
    else $error("color given with zero intensity");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_intensity) && $stable(out_color_out))
    else $error("stalled result changed");

endmodule

bind radial_wave_delay_intensity_top rwdi_checker u_rwdi_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_command(in_command), .out_valid(out_valid), .out_stall(out_stall),
  .out_intensity(out_intensity), .out_color_out(out_color_out)
);

// ===== tb/radial_wave_delay_intensity_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for radial_wave_delay_intensity_top: pushes samples, queries lights,
// predicts each intensity and color in a scoreboard class. Depends on rwdi_pkg and the top.
module radial_wave_delay_intensity_top_tb;
  import rwdi_pkg::*;

  localparam int DEPTH = 1024;
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int WATCH_LIMIT = 20000;

  class wave_scoreboard;
    logic [15:0] org_x, org_y, org_z, speed_reg, decay_reg;
    logic [7:0]  rate_reg;
    logic [31:0] color_reg;
    logic [15:0] history [DEPTH];
    int unsigned newest;
    logic [15:0] exp_int [$];
    logic [31:0] exp_col [$];
    int errors;
    int queries;
    int lit;

    function void reset_state();
      org_x = 256; org_y = 256; org_z = 256; speed_reg = 256; decay_reg = 4096;
      rate_reg = 60; color_reg = 32'h8080_80FF;
      foreach (history[i]) history[i] = '0;
      newest = 0; errors = 0; queries = 0; lit = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ORIGIN_X:   org_x = val[15:0];
        REG_ORIGIN_Y:   org_y = val[15:0];
        REG_ORIGIN_Z:   org_z = val[15:0];
        REG_WAVE_SPEED: speed_reg = val[15:0];
        REG_DECAY:      decay_reg = val[15:0];
        REG_FRAME_RATE: rate_reg = val[7:0];
        REG_COLOR:      color_reg = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0; b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // log2(x/256) in Q16.16
    function longint log2_fix(logic [63:0] x);
      int n;
      logic [63:0] t, m, frac;
      n = 0; t = x; frac = 0;
      while (t > 1) begin
        t = t >> 1;
        n++;
      end
      m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac[0] = 1'b1;
        end
      end
      return longint'(n - 8) * 65536 + longint'(frac);
    endfunction

    function logic [31:0] exp2_fix(logic [63:0] p);
      logic [63:0] r, c, q;
      int unsigned n;
      r = 64'd1 << 30; c = 64'd2 << 30;
      n = p[17:16];
      for (int k = 1; k <= 16; k++) begin
        c = floor_root(c << 30);
        if (p[16 - k]) r = (r * c + (64'd1 << 29)) >> 30;
      end
      q = ((r << n) + (64'd1 << 17)) >> 18;
      if (q < 4096) q = 4096;
      if (q > 40960) q = 40960;
      return q[31:0];
    endfunction

    function logic [31:0] attenuation(logic [63:0] x, longint decay);
      longint prod;
      logic [63:0] pq;
      if (x == 0) return (decay >= 0) ? 32'd4096 : 32'd40960;
      prod = log2_fix(x) * decay;
      if (prod <= 0) return 32'd4096;
      pq = 64'(prod) >> 12;
      if (pq == 0) return 32'd4096;
      if (pq >= (64'd4 << 16)) return 32'd40960;
      return exp2_fix(pq);
    endfunction

    function void note_input(logic cmd, logic [15:0] smp,
                             logic signed [15:0] lx, ly, lz);
      longint dx, dy, dz;
      logic [63:0] sum, d, spd, steps, val, pw, q;
      int unsigned pos;
      if (cmd == CMD_PUSH) begin
        newest = (newest + 1) % DEPTH;
        history[newest] = smp;
        return;
      end
      dx = longint'(lx) - longint'($signed(org_x));
      dy = longint'(ly) - longint'($signed(org_y));
      dz = longint'(lz) - longint'($signed(org_z));
      sum = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      d = floor_root(sum);
      spd = (speed_reg == 0) ? 64'd1 : 64'(speed_reg);
      steps = (2 * d * 64'(rate_reg) + spd) / (2 * spd);
      if (steps >= DEPTH) begin
        val = 0;
      end else begin
        pos = (newest + DEPTH - int'(steps)) % DEPTH;
        val = history[pos];
      end
      pw = attenuation(3 * d, longint'($signed(decay_reg)));
      q = (val << 12) / pw;
      exp_int.push_back(q[15:0]);
      exp_col.push_back(q[15:0] != 0 ? color_reg : 32'd0);
      queries++;
      if (q[15:0] != 0) lit++;
    endfunction

    function void check_result(logic [15:0] got_int, logic [31:0] got_col);
      logic [15:0] ei;
      logic [31:0] ec;
      if (exp_int.size() == 0) begin
        $display("%0t: unexpected result intensity=%h color=%h", $time, got_int, got_col);
        errors++;
        return;
      end
      ei = exp_int.pop_front();
      ec = exp_col.pop_front();
      if (got_int !== ei) begin
        $display("%0t: intensity mismatch expected %h actual %h", $time, ei, got_int);
        errors++;
      end
      if (got_col !== ec) begin
        $display("%0t: color mismatch expected %h actual %h", $time, ec, got_col);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_command;
  logic [15:0] in_sample;
  logic signed [15:0] in_light_x, in_light_y, in_light_z;
  logic out_valid, out_stall;
  logic [15:0] out_intensity;
  logic [31:0] out_color_out;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  wave_scoreboard board;
  int send_idle_pct, recv_idle_pct;
  int idle_cycles;

  radial_wave_delay_intensity_top #(.HISTORY_DEPTH(DEPTH)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    board.reset_state();
  end

  // receiver: random stall, check on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_intensity, out_color_out);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // valid stays high into the next item unless the sender idles
  task automatic send_item(logic cmd, logic [15:0] smp, logic [15:0] lx, ly, lz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample <= smp;
    in_light_x <= lx;
    in_light_y <= ly;
    in_light_z <= lz;
    do @(posedge clk); while (in_stall);
    board.note_input(cmd, smp, lx, ly, lz);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.exp_int.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offsets of up to span around the origin for most queries, some fully random lights
  task automatic random_item(int span);
    if ($urandom_range(99) < 55) begin
      send_item(CMD_PUSH, 16'($urandom), 16'h0, 16'h0, 16'h0);
    end else if ($urandom_range(99) < 85) begin
      send_item(CMD_QUERY, 16'($urandom),
                16'(int'($signed(board.org_x)) + $urandom_range(2 * span) - span),
                16'(int'($signed(board.org_y)) + $urandom_range(2 * span) - span),
                16'(int'($signed(board.org_z)) + $urandom_range(2 * span) - span));
    end else begin
      send_item(CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_config();
    write_cfg(REG_ORIGIN_X, $urandom);
    write_cfg(REG_ORIGIN_Y, $urandom);
    write_cfg(REG_ORIGIN_Z, $urandom);
    write_cfg(REG_WAVE_SPEED, $urandom_range(65535, 1));
    write_cfg(REG_DECAY, $urandom);
    write_cfg(REG_FRAME_RATE, $urandom_range(255, 1));
    write_cfg(REG_COLOR, $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_command = CMD_PUSH; in_sample = '0;
    in_light_x = '0; in_light_y = '0; in_light_z = '0;
    cfg_we = 1'b0; cfg_index = REG_ORIGIN_X; cfg_wdata = '0;
    send_idle_pct = 8; recv_idle_pct = 45;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: query before any push, origin hit, field extremes
    send_item(CMD_QUERY, 16'h0, 16'sd256, 16'sd256, 16'sd256);
    send_item(CMD_QUERY, 16'h0, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(CMD_PUSH, 16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_item(CMD_PUSH, 16'h0000, 16'h0, 16'h0, 16'h0);
    send_item(CMD_PUSH, 16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_item(CMD_QUERY, 16'hFFFF, 16'sd256, 16'sd256, 16'sd256);
    send_item(CMD_QUERY, 16'h0, 16'sd256 + 16'sd4, 16'sd256, 16'sd256);
    send_item(CMD_QUERY, 16'h0, 16'sd300, 16'sd200, 16'sd260);
    send_item(CMD_QUERY, 16'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    wait_drained();
    // most negative decay at and off zero distance, maximum rate and speed
    write_cfg(REG_DECAY, 32'h8000);
    write_cfg(REG_WAVE_SPEED, 32'hFFFF);
    write_cfg(REG_FRAME_RATE, 32'hFF);
    write_cfg(REG_COLOR, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 16'h0, 16'sd256, 16'sd256, 16'sd256);
    send_item(CMD_QUERY, 16'h0, 16'sd1000, 16'sd256, 16'sd256);
    wait_drained();
    write_cfg(REG_DECAY, 32'h7FFF);
    write_cfg(REG_WAVE_SPEED, 32'h1);
    write_cfg(REG_FRAME_RATE, 32'h1);
    write_cfg(REG_ORIGIN_X, 32'h8000);
    write_cfg(REG_ORIGIN_Y, 32'h7FFF);
    write_cfg(REG_ORIGIN_Z, 32'h0);
    send_item(CMD_QUERY, 16'h0, 16'h8000, 16'h7FFF, 16'h0);
    send_item(CMD_QUERY, 16'h0, 16'h8001, 16'h7FFF, 16'h0);
    send_item(CMD_QUERY, 16'h0, 16'h7FFF, 16'h8000, 16'h7FFF);
    wait_drained();
    write_cfg(REG_UNUSED, 32'h1234_5678);
    write_cfg(REG_ORIGIN_X, 32'h0);
    write_cfg(REG_ORIGIN_Y, 32'h0);
    write_cfg(REG_ORIGIN_Z, 32'h0);
    write_cfg(REG_WAVE_SPEED, 32'd25600);
    write_cfg(REG_DECAY, 32'd2048);
    write_cfg(REG_FRAME_RATE, 32'd60);
    write_cfg(REG_COLOR, 32'h00FF_00FF);
    // fill the whole history so wrap-around reads are real samples
    for (int i = 0; i < DEPTH + 8; i++) send_item(CMD_PUSH, 16'($urandom), 16'h0, 16'h0, 16'h0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 45; recv_idle_pct = 8;
      end
      if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int i = 0; i < 45; i++) random_item(ph[0] ? 16000 : 2000);
      wait_drained();
      random_config();
      if (ph == 3) write_cfg(REG_WAVE_SPEED, 32'd32000);
    end
    wait_drained();

    $display("Run covered %0d queries (%0d lit) over pushes, wrap-around and config sweeps.",
             board.queries, board.lit);
    if (board.errors == 0 && board.exp_int.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
